[hw/rtl/dls_pkg.sv]
package dls_pkg;

    localparam int TIMER_BITS_DEF = 12;
    localparam int CFG_W          = 12;
    localparam int CFG_IDX_W      = 3;
    localparam int STATE_W        = 4;
    localparam int DEFECT_CNT     = 6;
    localparam int DEFECT_SIDE    = 3;

    localparam logic [2:0]       HOLDOFF_TICKS    = 3'd5;
    localparam logic [1:0]       DISORDERLY_TICKS = 2'd3;
    localparam int               RETRY_MIN_MS     = 5000;
    localparam logic [CFG_W-1:0] RETRY_MIN_TICKS  = CFG_W'(RETRY_MIN_MS / 1000);

    // line state codes
    localparam logic [STATE_W-1:0] ST_IDLE        = 4'd0;
    localparam logic [STATE_W-1:0] ST_ACTIVATING  = 4'd1;
    localparam logic [STATE_W-1:0] ST_L3          = 4'd2;
    localparam logic [STATE_W-1:0] ST_SHOW_L0     = 4'd3;
    localparam logic [STATE_W-1:0] ST_SHOW_L1     = 4'd5;
    localparam logic [STATE_W-1:0] ST_INIT        = 4'd6;
    localparam logic [STATE_W-1:0] ST_HANDSHAKE_B = 4'd8;
    localparam logic [STATE_W-1:0] ST_DISORDERLY  = 4'd9;
    localparam logic [STATE_W-1:0] ST_RETRY       = 4'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACT_TIMEOUT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIMEOUT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_WAIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_ENABLE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LCD_TRIGGER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LOS_TRIGGER  = 3'd5;

    localparam logic [CFG_W-1:0] ACT_TIMEOUT_RST  = 12'd300;
    localparam logic [CFG_W-1:0] INIT_TIMEOUT_RST = 12'd20;
    localparam logic [CFG_W-1:0] RETRY_WAIT_RST   = 12'd5;
    localparam logic             RETRY_ENABLE_RST = 1'b1;
    localparam logic [CFG_W-1:0] LCD_TRIGGER_RST  = 12'd15;
    localparam logic [CFG_W-1:0] LOS_TRIGGER_RST  = 12'd5;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_ACT_TIMEOUT  = 3'd1,
        EV_INIT_TIMEOUT = 3'd2,
        EV_DEFECT_SHUT  = 3'd3,
        EV_RETRY        = 3'd4
    } t_event;

    typedef struct packed {
        logic               req_type;
        logic [STATE_W-1:0] reported_state;
        logic               fm_data_ok;
        logic [2:0]         near_status;
        logic               near_los_change;
        logic [2:0]         far_status;
        logic               far_los_change;
    } t_req;

    typedef struct packed {
        logic [STATE_W-1:0] line_state;
        t_event             event_code;
        logic               request_idle;
        logic               request_start;
        logic               defects_polled;
    } t_rsp;

    typedef struct packed {
        logic [CFG_W-1:0] act_timeout_ticks;
        logic [CFG_W-1:0] init_timeout_ticks;
        logic [CFG_W-1:0] retry_wait_ticks;
        logic             retry_enable;
        logic [CFG_W-1:0] lcd_trigger_ticks;
        logic [CFG_W-1:0] los_trigger_ticks;
    } t_cfg;

endpackage

[hw/rtl/dls_req_if.sv]
interface dls_req_if;
    logic          valid;
    logic          ready;
    dls_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dls_rsp_if.sv]
interface dls_rsp_if;
    logic          valid;
    logic          ready;
    dls_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/dls_cfg_if.sv]
interface dls_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [dls_pkg::CFG_IDX_W-1:0]   index;
    logic [dls_pkg::CFG_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/dls_cfg_regs.sv]
module dls_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr,
    input  logic [dls_pkg::CFG_IDX_W-1:0] i_idx,
    input  logic [dls_pkg::CFG_W-1:0]     i_data,
    output dls_pkg::t_cfg                 o_cfg
);

    dls_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.act_timeout_ticks  <= dls_pkg::ACT_TIMEOUT_RST;
            r_cfg.init_timeout_ticks <= dls_pkg::INIT_TIMEOUT_RST;
            r_cfg.retry_wait_ticks   <= dls_pkg::RETRY_WAIT_RST;
            r_cfg.retry_enable       <= dls_pkg::RETRY_ENABLE_RST;
            r_cfg.lcd_trigger_ticks  <= dls_pkg::LCD_TRIGGER_RST;
            r_cfg.los_trigger_ticks  <= dls_pkg::LOS_TRIGGER_RST;
        end else if (i_wr) begin
            unique case (i_idx)
                dls_pkg::CFG_ACT_TIMEOUT:  r_cfg.act_timeout_ticks  <= i_data;
                dls_pkg::CFG_INIT_TIMEOUT: r_cfg.init_timeout_ticks <= i_data;
                dls_pkg::CFG_RETRY_WAIT:   r_cfg.retry_wait_ticks   <= i_data;
                dls_pkg::CFG_RETRY_ENABLE: r_cfg.retry_enable       <= i_data[0];
                dls_pkg::CFG_LCD_TRIGGER:  r_cfg.lcd_trigger_ticks  <= i_data;
                dls_pkg::CFG_LOS_TRIGGER:  r_cfg.los_trigger_ticks  <= i_data;
                default: ;  // unmapped index
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/dls_line_fsm.sv]
module dls_line_fsm #(
    parameter int TIMER_BITS = dls_pkg::TIMER_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  dls_pkg::t_req i_req,
    input  dls_pkg::t_cfg i_cfg,
    output dls_pkg::t_rsp o_rsp
);

    localparam int CW   = (TIMER_BITS > dls_pkg::CFG_W) ? TIMER_BITS : dls_pkg::CFG_W;
    localparam int NDEF = dls_pkg::DEFECT_CNT;
    localparam int NS   = dls_pkg::DEFECT_SIDE;

    typedef logic [TIMER_BITS-1:0] t_timer;

    logic [dls_pkg::STATE_W-1:0] r_state, n_state;
    t_timer                      r_act, n_act;
    t_timer                      r_init, n_init;
    t_timer                      r_retry, n_retry;
    logic [1:0]                  r_disord, n_disord;
    logic [2:0]                  r_holdoff, n_holdoff;
    t_timer                      r_persist [NDEF];
    t_timer                      n_persist [NDEF];

    t_timer                  act_inc, init_inc, retry_inc;
    logic [1:0]              disord_inc;
    logic [2:0]              holdoff_inc;
    logic [NDEF-1:0]         defect_on;
    t_timer                  bumped [NDEF];
    logic                    defect_hit;
    logic [dls_pkg::CFG_W-1:0] retry_wait;
    dls_pkg::t_event         ev;
    logic                    req_idle, req_start, polled;

    function automatic t_timer sat_inc(t_timer v);
        return (&v) ? v : v + t_timer'(1);
    endfunction

    function automatic logic reached(t_timer v, logic [dls_pkg::CFG_W-1:0] th);
        return CW'(v) >= CW'(th);
    endfunction

    assign act_inc     = sat_inc(r_act);
    assign init_inc    = sat_inc(r_init);
    assign retry_inc   = sat_inc(r_retry);
    assign disord_inc  = (&r_disord) ? r_disord : r_disord + 2'd1;
    assign holdoff_inc = (&r_holdoff) ? r_holdoff : r_holdoff + 3'd1;
    assign retry_wait  = (i_cfg.retry_wait_ticks > dls_pkg::RETRY_MIN_TICKS) ?
                         i_cfg.retry_wait_ticks : dls_pkg::RETRY_MIN_TICKS;

    // los counters also advance on the change bit
    assign defect_on = {i_req.far_status[2:1],
                        i_req.far_status[0] | i_req.far_los_change,
                        i_req.near_status[2:1],
                        i_req.near_status[0] | i_req.near_los_change};

    always_comb begin
        for (int k = 0; k < NDEF; k++) begin
            bumped[k] = defect_on[k] ? sat_inc(r_persist[k]) : '0;
        end
    end

    assign defect_hit = reached(bumped[0],      i_cfg.los_trigger_ticks) ||
                        reached(bumped[1],      i_cfg.lcd_trigger_ticks) ||
                        reached(bumped[2],      i_cfg.lcd_trigger_ticks) ||
                        reached(bumped[NS],     i_cfg.los_trigger_ticks) ||
                        reached(bumped[NS + 1], i_cfg.lcd_trigger_ticks) ||
                        reached(bumped[NS + 2], i_cfg.lcd_trigger_ticks);

    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_init    = r_init;
        n_retry   = r_retry;
        n_disord  = r_disord;
        n_holdoff = r_holdoff;
        for (int k = 0; k < NDEF; k++) begin
            n_persist[k] = r_persist[k];
        end
        ev        = dls_pkg::EV_NONE;
        req_idle  = 1'b0;
        req_start = 1'b0;
        polled    = 1'b0;

        if (i_req.req_type) begin
            n_state = i_req.reported_state;
        end else begin
            unique case (r_state) inside
                dls_pkg::ST_IDLE: begin
                    n_retry = '0;
                    n_act   = '0;
                end
                dls_pkg::ST_ACTIVATING: begin
                    n_act = act_inc;
                    if (reached(act_inc, i_cfg.act_timeout_ticks)) begin
                        ev      = dls_pkg::EV_ACT_TIMEOUT;
                        n_state = dls_pkg::ST_DISORDERLY;
                        n_act   = '0;
                    end
                end
                dls_pkg::ST_L3: ;
                [dls_pkg::ST_SHOW_L0:dls_pkg::ST_SHOW_L1]: begin
                    n_holdoff = holdoff_inc;
                    if (holdoff_inc >= dls_pkg::HOLDOFF_TICKS) begin
                        if (!i_req.fm_data_ok) begin
                            n_holdoff = '0;
                        end else begin
                            polled = 1'b1;
                            if (defect_hit) begin
                                ev      = dls_pkg::EV_DEFECT_SHUT;
                                n_state = dls_pkg::ST_DISORDERLY;
                                for (int k = 0; k < NDEF; k++) begin
                                    n_persist[k] = '0;
                                end
                            end else begin
                                for (int k = 0; k < NDEF; k++) begin
                                    n_persist[k] = bumped[k];
                                end
                            end
                        end
                    end
                end
                [dls_pkg::ST_INIT:dls_pkg::ST_HANDSHAKE_B]: begin
                    n_init = init_inc;
                    if (reached(init_inc, i_cfg.init_timeout_ticks)) begin
                        ev      = dls_pkg::EV_INIT_TIMEOUT;
                        n_init  = '0;
                        n_state = dls_pkg::ST_DISORDERLY;
                    end
                end
                dls_pkg::ST_DISORDERLY: begin
                    n_disord = disord_inc;
                    if (disord_inc >= dls_pkg::DISORDERLY_TICKS) begin
                        n_holdoff = '0;
                        n_disord  = '0;
                        req_idle  = 1'b1;
                        if (i_cfg.retry_enable) begin
                            n_state = dls_pkg::ST_RETRY;
                            n_retry = '0;
                        end
                    end
                end
                dls_pkg::ST_RETRY: begin
                    if (i_cfg.retry_enable) begin
                        n_retry = retry_inc;
                        if (reached(retry_inc, retry_wait)) begin
                            ev        = dls_pkg::EV_RETRY;
                            n_retry   = '0;
                            req_start = 1'b1;
                        end
                    end else begin
                        n_state = dls_pkg::ST_IDLE;
                    end
                end
                default: n_state = dls_pkg::ST_IDLE;  // undefined state code
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dls_pkg::ST_IDLE;
            r_act     <= '0;
            r_init    <= '0;
            r_retry   <= '0;
            r_disord  <= '0;
            r_holdoff <= '0;
            for (int k = 0; k < NDEF; k++) begin
                r_persist[k] <= '0;
            end
        end else if (i_step) begin
            r_state   <= n_state;
            r_act     <= n_act;
            r_init    <= n_init;
            r_retry   <= n_retry;
            r_disord  <= n_disord;
            r_holdoff <= n_holdoff;
            for (int k = 0; k < NDEF; k++) begin
                r_persist[k] <= n_persist[k];
            end
        end
    end

    assign o_rsp.line_state     = n_state;
    assign o_rsp.event_code     = ev;
    assign o_rsp.request_idle   = req_idle;
    assign o_rsp.request_start  = req_start;
    assign o_rsp.defects_polled = polled;

endmodule

[hw/rtl/dsl_line_supervisor_unit.sv]
// dsl line supervisor
// i_req carries poll ticks (req_type 0) with near/far defect bits, or line state
// reports from the modem (req_type 1). every accepted request produces exactly
// one result on o_rsp: the new line state, an event code, idle/start requests
// to the modem and a flag telling whether defect bits were evaluated.
// i_cfg writes the timeout, retry and trigger registers by index; it is always
// ready and should only be used while no request is in flight.
// flow: an accepted request is held in the input register, is evaluated from
// there and lands in the result register, and is offered on o_rsp from then on.
// throughput: one request per cycle while o_rsp is not stalled; all state
// updates for one request are done in the evaluation between the input and
// result registers.
// when o_rsp is stalled the result register holds, the input register keeps
// one more request, and i_req.ready drops once both are full.
// reset (synchronous, active low) returns the line to idle, clears all timers
// and persistence counters and loads the default register values.
module dsl_line_supervisor_unit #(
    parameter int TIMER_BITS = dls_pkg::TIMER_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dls_req_if.sink   i_req,
    dls_rsp_if.source o_rsp,
    dls_cfg_if.sink   i_cfg
);

    dls_pkg::t_cfg cfg;
    dls_pkg::t_rsp core_rsp;

    logic          r_s1_valid;
    dls_pkg::t_req r_s1_req;
    logic          r_out_valid;
    dls_pkg::t_rsp r_out_rsp;
    logic          step;
    logic          in_fire;

    assign step    = r_s1_valid && (!r_out_valid || o_rsp.ready);
    assign in_fire = i_req.valid && i_req.ready;

    assign i_req.ready = !r_s1_valid || step;
    assign i_cfg.ready = 1'b1;

    dls_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg.valid && i_cfg.ready),
        .i_idx   (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cfg   (cfg)
    );

    dls_line_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_s1_req),
        .i_cfg   (cfg),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (step) begin
                r_s1_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req <= i_req.data;
        end
        if (step) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out_rsp;

    // a held request is never dropped while the result side is stalled
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !step |=> r_s1_valid && $stable(r_s1_req))
        else $error("input register lost a request under stall");

    a_start_is_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_rsp.request_start |->
            r_out_rsp.event_code == dls_pkg::EV_RETRY &&
            r_out_rsp.line_state == dls_pkg::ST_RETRY)
        else $error("start request outside a completed retry");

    a_shutdown_polled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_rsp.event_code == dls_pkg::EV_DEFECT_SHUT |->
            r_out_rsp.defects_polled &&
            r_out_rsp.line_state == dls_pkg::ST_DISORDERLY)
        else $error("defect shutdown without a defect poll");

    a_idle_req_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_rsp.request_idle |->
            r_out_rsp.line_state == dls_pkg::ST_RETRY ||
            r_out_rsp.line_state == dls_pkg::ST_DISORDERLY)
        else $error("idle request from an unexpected state");

endmodule

[tb/sv/dls_result_checker.sv]
`timescale 1ns / 1ps

module dls_result_checker
    import dls_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  t_req                 i_req_data,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  t_rsp                 i_rsp_data,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_errors,
    output int                   o_pending
);

    localparam int TIMER_MAX = (1 << TIMER_BITS_DEF) - 1;

    // register copies
    int act_limit, init_limit, retry_wait, lcd_limit, los_limit;
    bit retry_on;

    // line model
    logic [STATE_W-1:0] line_st;
    int act_ticks, init_ticks, dis_ticks, retry_ticks, holdoff_ticks;
    int persist [DEFECT_CNT];

    t_rsp line_result_q [$];
    t_rsp want;
    int   err_cnt = 0;

    function automatic int sat_inc(input int v, input int ceiling);
        return (v >= ceiling) ? ceiling : v + 1;
    endfunction

    function automatic t_rsp supervise(input t_req r);
        t_rsp       res;
        logic [5:0] on;
        bit         hit;
        int         wait_ticks;
        res = '0;
        if (r.req_type) begin
            line_st = r.reported_state;
        end else if (line_st == ST_IDLE) begin
            retry_ticks = 0;
            act_ticks   = 0;
        end else if (line_st == ST_ACTIVATING) begin
            act_ticks = sat_inc(act_ticks, TIMER_MAX);
            if (act_ticks >= act_limit) begin
                res.event_code = EV_ACT_TIMEOUT;
                line_st        = ST_DISORDERLY;
                act_ticks      = 0;
            end
        end else if (line_st >= ST_SHOW_L0 && line_st <= ST_SHOW_L1) begin
            holdoff_ticks = sat_inc(holdoff_ticks, 7);
            if (holdoff_ticks >= HOLDOFF_TICKS) begin
                if (!r.fm_data_ok) begin
                    holdoff_ticks = 0;
                end else begin
                    res.defects_polled = 1'b1;
                    // near los, near fast, near interleaved, then the far side
                    on  = {r.far_status[2:1], r.far_status[0] | r.far_los_change,
                           r.near_status[2:1], r.near_status[0] | r.near_los_change};
                    hit = 1'b0;
                    for (int i = 0; i < DEFECT_CNT; i++) begin
                        persist[i] = on[i] ? sat_inc(persist[i], TIMER_MAX) : 0;
                        if (persist[i] >= ((i % DEFECT_SIDE == 0) ? los_limit : lcd_limit))
                            hit = 1'b1;
                    end
                    if (hit) begin
                        line_st        = ST_DISORDERLY;
                        res.event_code = EV_DEFECT_SHUT;
                        for (int i = 0; i < DEFECT_CNT; i++) persist[i] = 0;
                    end
                end
            end
        end else if (line_st >= ST_INIT && line_st <= ST_HANDSHAKE_B) begin
            init_ticks = sat_inc(init_ticks, TIMER_MAX);
            if (init_ticks >= init_limit) begin
                res.event_code = EV_INIT_TIMEOUT;
                init_ticks     = 0;
                line_st        = ST_DISORDERLY;
            end
        end else if (line_st == ST_DISORDERLY) begin
            dis_ticks = sat_inc(dis_ticks, 3);
            if (dis_ticks >= DISORDERLY_TICKS) begin
                holdoff_ticks    = 0;
                dis_ticks        = 0;
                res.request_idle = 1'b1;
                if (retry_on) begin
                    line_st     = ST_RETRY;
                    retry_ticks = 0;
                end
            end
        end else if (line_st == ST_RETRY) begin
            if (retry_on) begin
                wait_ticks  = (retry_wait > RETRY_MIN_TICKS) ? retry_wait : RETRY_MIN_TICKS;
                retry_ticks = sat_inc(retry_ticks, TIMER_MAX);
                if (retry_ticks >= wait_ticks) begin
                    res.event_code    = EV_RETRY;
                    retry_ticks       = 0;
                    res.request_start = 1'b1;
                end
            end else begin
                line_st = ST_IDLE;
            end
        end else if (line_st > ST_RETRY) begin
            line_st = ST_IDLE;
        end
        // l3 ticks fall through with nothing to do
        res.line_state = line_st;
        return res;
    endfunction

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("%s", msg);
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v)
            flag_error($sformatf("mismatch %s: expected %0d, got %0d", name, exp_v, got_v));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            act_limit     = ACT_TIMEOUT_RST;
            init_limit    = INIT_TIMEOUT_RST;
            retry_wait    = RETRY_WAIT_RST;
            retry_on      = RETRY_ENABLE_RST;
            lcd_limit     = LCD_TRIGGER_RST;
            los_limit     = LOS_TRIGGER_RST;
            line_st       = ST_IDLE;
            act_ticks     = 0;
            init_ticks    = 0;
            dis_ticks     = 0;
            retry_ticks   = 0;
            holdoff_ticks = 0;
            for (int i = 0; i < DEFECT_CNT; i++) persist[i] = 0;
            line_result_q.delete();
        end else begin
            // a result leaving now belongs to an older request, so pop first
            if (i_rsp_valid && i_rsp_ready) begin
                if (line_result_q.size() == 0) begin
                    flag_error($sformatf("unexpected result: state %0d event %0d",
                                         i_rsp_data.line_state, i_rsp_data.event_code));
                end else begin
                    want = line_result_q.pop_front();
                    check_field("line_state", want.line_state, i_rsp_data.line_state);
                    check_field("event_code", int'(want.event_code),
                                int'(i_rsp_data.event_code));
                    check_field("request_idle", want.request_idle, i_rsp_data.request_idle);
                    check_field("request_start", want.request_start,
                                i_rsp_data.request_start);
                    check_field("defects_polled", want.defects_polled,
                                i_rsp_data.defects_polled);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_ACT_TIMEOUT:  act_limit  = i_cfg_data;
                    CFG_INIT_TIMEOUT: init_limit = i_cfg_data;
                    CFG_RETRY_WAIT:   retry_wait = i_cfg_data;
                    CFG_RETRY_ENABLE: retry_on   = i_cfg_data[0];
                    CFG_LCD_TRIGGER:  lcd_limit  = i_cfg_data;
                    CFG_LOS_TRIGGER:  los_limit  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready)
                line_result_q.push_back(supervise(i_req_data));
        end
        o_errors  <= err_cnt;
        o_pending <= line_result_q.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import dls_pkg::*;

    localparam int REQ_W       = $bits(t_req);
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 175;
    localparam int CYCLE_LIMIT = 200000;

    // indexes past the register list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct   = 0;
    int   sink_stall_pct = 0;
    int   chk_errors;
    int   chk_pending;
    int   cycle_cnt = 0;
    int   src_pct_tab  [4] = '{0, 63, 0, 8};
    int   sink_pct_tab [4] = '{0, 0, 63, 8};

    dls_req_if req_if ();
    dls_rsp_if rsp_if ();
    dls_cfg_if cfg_if ();

    dsl_line_supervisor_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    dls_result_checker chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_if.valid),
        .i_req_ready (req_if.ready),
        .i_req_data  (req_if.data),
        .i_rsp_valid (rsp_if.valid),
        .i_rsp_ready (rsp_if.ready),
        .i_rsp_data  (rsp_if.data),
        .i_cfg_valid (cfg_if.valid),
        .i_cfg_ready (cfg_if.ready),
        .i_cfg_index (cfg_if.index),
        .i_cfg_data  (cfg_if.data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    always @(negedge i_clk) rsp_if.ready = ($urandom_range(99) >= sink_stall_pct);

    function automatic t_req tick_req(input bit fm, input logic [2:0] ns, input bit nlc,
                                      input logic [2:0] fs, input bit flc);
        t_req r;
        // reported_state is ignored on ticks, keep it random
        r                 = t_req'(REQ_W'($urandom));
        r.req_type        = 1'b0;
        r.fm_data_ok      = fm;
        r.near_status     = ns;
        r.near_los_change = nlc;
        r.far_status      = fs;
        r.far_los_change  = flc;
        return r;
    endfunction

    function automatic t_req report_req(input logic [STATE_W-1:0] st);
        t_req r;
        r                = t_req'(REQ_W'($urandom));
        r.req_type       = 1'b1;
        r.reported_state = st;
        return r;
    endfunction

    task automatic send_req(input t_req r);
        while ($urandom_range(99) < src_idle_pct) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        req_if.valid = 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    initial begin : stimulus
        t_req               r;
        int                 sent;
        int                 n;
        int                 kind;
        logic [STATE_W-1:0] st;
        logic [2:0]         near_stuck;
        logic [2:0]         far_stuck;
        logic [CFG_W-1:0]   act_v, init_v, rwait_v, ren_v, lcd_v, los_v;

        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = '0;
        cfg_if.data  = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed walk through the line states
        write_reg(CFG_ACT_TIMEOUT, 12'd2);
        write_reg(CFG_INIT_TIMEOUT, 12'd0);
        write_reg(CFG_RETRY_WAIT, 12'd0);
        write_reg(CFG_RETRY_ENABLE, 12'd1);
        write_reg(CFG_LCD_TRIGGER, 12'd3);
        write_reg(CFG_LOS_TRIGGER, 12'd2);
        cfg_if.valid = 1'b0;
        send_req(tick_req(1'b1, 3'b111, 1'b1, 3'b111, 1'b1));
        send_req(tick_req(1'b0, 3'b000, 1'b0, 3'b000, 1'b0));
        send_req(report_req(ST_ACTIVATING));
        repeat (2) send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b000, 1'b0));
        // disorderly wait, then retry delay clamped up to the minimum
        repeat (3) send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b000, 1'b0));
        repeat (5) send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b000, 1'b0));
        // zero init threshold fires on the first tick
        send_req(report_req(ST_HANDSHAKE_B));
        send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b000, 1'b0));
        send_req(report_req(ST_SHOW_L1));
        repeat (4) send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b000, 1'b0));
        send_req(tick_req(1'b1, 3'b000, 1'b1, 3'b000, 1'b0));
        send_req(tick_req(1'b1, 3'b010, 1'b0, 3'b000, 1'b0));
        send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b001, 1'b0));
        send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b001, 1'b1));
        // unknown state code drops back to idle
        send_req(report_req(ST_RETRY + 4'd2));
        send_req(tick_req(1'b1, 3'b000, 1'b0, 3'b000, 1'b0));

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0: begin
                    act_v = '0; init_v = '0; rwait_v = '0;
                    ren_v = '0; lcd_v  = '0; los_v   = '0;
                end
                1: begin
                    act_v = '1; init_v = '1; rwait_v = '1;
                    ren_v = '1; lcd_v  = '1; los_v   = '1;
                end
                default: begin
                    act_v   = CFG_W'($urandom_range(0, 40));
                    init_v  = CFG_W'($urandom_range(0, 25));
                    rwait_v = CFG_W'($urandom_range(0, 12));
                    ren_v   = CFG_W'($urandom);
                    lcd_v   = CFG_W'($urandom_range(0, 20));
                    los_v   = CFG_W'($urandom_range(0, 10));
                end
            endcase
            write_reg(CFG_ACT_TIMEOUT, act_v);
            write_reg(CFG_INIT_TIMEOUT, init_v);
            write_reg(CFG_RETRY_WAIT, rwait_v);
            write_reg(CFG_RETRY_ENABLE, ren_v);
            write_reg(CFG_LCD_TRIGGER, lcd_v);
            write_reg(CFG_LOS_TRIGGER, los_v);
            write_reg(($urandom_range(1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
            cfg_if.valid   = 1'b0;
            src_idle_pct   = src_pct_tab[p % 4];
            sink_stall_pct = sink_pct_tab[p % 4];

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // mostly a report followed by a run of ticks, sometimes just more ticks
                if ($urandom_range(9) != 0) begin
                    kind = $urandom_range(99);
                    if (kind < 35)      st = ST_SHOW_L0 + STATE_W'($urandom_range(2));
                    else if (kind < 50) st = ST_ACTIVATING;
                    else if (kind < 65) st = ST_INIT + STATE_W'($urandom_range(2));
                    else if (kind < 75) st = ST_DISORDERLY;
                    else if (kind < 85) st = ST_RETRY;
                    else if (kind < 95) st = ($urandom_range(1) != 0) ? ST_IDLE : ST_L3;
                    else                st = ST_RETRY + 4'd1 + STATE_W'($urandom_range(4));
                    send_req(report_req(st));
                    sent++;
                end
                near_stuck = ($urandom_range(1) != 0) ? 3'b001 << $urandom_range(2) : 3'b000;
                far_stuck  = ($urandom_range(1) != 0) ? 3'b001 << $urandom_range(2) : 3'b000;
                n = $urandom_range(1, 30);
                repeat (n) begin
                    if ($urandom_range(99) < 12) begin
                        r = t_req'(REQ_W'($urandom));
                    end else begin
                        r = tick_req($urandom_range(9) != 0,
                                     near_stuck | (($urandom_range(3) == 0) ?
                                                   3'($urandom) : 3'b000),
                                     $urandom_range(3) == 0,
                                     far_stuck | (($urandom_range(3) == 0) ?
                                                  3'($urandom) : 3'b000),
                                     $urandom_range(3) == 0);
                    end
                    send_req(r);
                    sent++;
                end
            end
        end

        drain();
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
